FILE: sv/scsa_pkg.sv
// Package with types, constants and command/status structs of the size-class slot allocator.
`timescale 1ns / 1ps
`default_nettype none

package scsa_pkg;

	// Geometry of the slot pools.
	localparam int SLOTS_PER_CLASS = 64;
	localparam int NUM_CLASSES     = 6;
	localparam int NUM_LIMIT_REGS  = 6;
	localparam int LIMIT_CLASSES   = (NUM_CLASSES < NUM_LIMIT_REGS) ? NUM_CLASSES : NUM_LIMIT_REGS;

	// Internal widths derived from the geometry.
	localparam int SLOT_W  = $clog2(SLOTS_PER_CLASS);
	localparam int LINK_W  = $clog2(SLOTS_PER_CLASS + 1);
	localparam int CLS_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int DEPTH   = NUM_CLASSES * SLOTS_PER_CLASS;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_DATA_W-1:0] LIMIT_RESET [NUM_LIMIT_REGS] =
		'{16'd8, 16'd16, 16'd32, 16'd64, 16'd128, 16'd256};

	// Request codes.
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_TOO_BIG   = 2'd1,
		ST_EXHAUSTED = 2'd2,
		ST_BAD_FREE  = 2'd3
	} status_t;

	// Input word.
	typedef struct packed {
		logic        action;
		logic [15:0] request_size;
		logic [2:0]  handle_class;
		logic [5:0]  handle_slot;
	} in_word_t;

	// Output word.
	typedef struct packed {
		status_t     status;
		logic [2:0]  size_class;
		logic [5:0]  slot_index;
		logic [6:0]  class_in_use;
		logic [31:0] class_alloc_total;
	} out_word_t;

	// Controller states.
	typedef enum logic [1:0] {
		S_INIT,
		S_IDLE,
		S_LOOKUP,
		S_POP
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic init_step;
		logic accept;
		logic lookup;
		logic pop;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic init_last;
		logic alloc_go;
		logic res_pend;
	} dp_status_t;

endpackage

`default_nettype wire

FILE: sv/scsa_ctrl.sv
// Controller state machine of the size-class slot allocator.
`timescale 1ns / 1ps
`default_nettype none

module scsa_ctrl (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_stall,
	input  scsa_pkg::dp_status_t   status,
	output scsa_pkg::ctrl_cmd_t    cmd
);
	import scsa_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        take_word;

	// A new word may enter while idle or while a pop finishes, unless a result is parked.
	assign take_word = in_valid && !in_stall;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT: begin
				if (status.init_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (take_word) begin
					state_d = S_LOOKUP;
				end
			end
			S_LOOKUP: begin
				state_d = status.alloc_go ? S_POP : S_IDLE;
			end
			S_POP: begin
				state_d = take_word ? S_LOOKUP : S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Output logic.
	always_comb begin
		in_stall      = !(((state_q == S_IDLE) || (state_q == S_POP)) && !status.res_pend);
		cmd.init_step = (state_q == S_INIT);
		cmd.accept    = take_word;
		cmd.lookup    = (state_q == S_LOOKUP);
		cmd.pop       = (state_q == S_POP);
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

FILE: sv/scsa_datapath.sv
// Datapath of the size-class slot allocator: limits, per-class counters, link memory, output buffer.
`timescale 1ns / 1ps
`default_nettype none

module scsa_datapath (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  scsa_pkg::ctrl_cmd_t                    cmd,
	output scsa_pkg::dp_status_t                   status,
	input  scsa_pkg::in_word_t                     in_word,
	output logic                                   out_valid,
	input  wire                                    out_stall,
	output scsa_pkg::out_word_t                    out_word,
	input  wire                                    cfg_we,
	input  wire  [scsa_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire  [scsa_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import scsa_pkg::*;

	// Registered request and configuration.
	in_word_t              req_q;
	logic [CFG_DATA_W-1:0] limit_q [LIMIT_CLASSES];

	// Per-class state.
	logic [LINK_W-1:0] head_q  [NUM_CLASSES];
	logic [LINK_W-1:0] used_q  [NUM_CLASSES];
	logic [31:0]       total_q [NUM_CLASSES];

	// Link memory and its clearing sweep.
	logic [LINK_W-1:0] link_mem [DEPTH];
	logic [LINK_W-1:0] rd_q;
	logic [CLS_W-1:0]  init_cls_q;
	logic [SLOT_W-1:0] init_slot_q;
	logic [CLS_W-1:0]  pop_cls_q;

	// Output buffer: one visible word and one parked word.
	out_word_t out_q;
	out_word_t res_q;
	logic      out_valid_q;
	logic      res_pend_q;

	// Lookup signals.
	logic              hit;
	logic [CLS_W-1:0]  found;
	logic              is_free;
	logic              hcls_ok;
	logic              slot_ok;
	logic [CLS_W-1:0]  sel_cls;
	logic [LINK_W-1:0] head_sel;
	logic [LINK_W-1:0] used_sel;
	logic [31:0]       total_sel;
	logic [SLOT_W-1:0] head_slot;
	logic [SLOT_W-1:0] free_slot;
	logic              alloc_go;
	logic              free_go;
	out_word_t         res_d;
	logic              out_free;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [LINK_W-1:0] mem_wdata;
	logic [ADDR_W-1:0] mem_raddr;

	// First class whose limit covers the request size.
	always_comb begin
		hit   = 1'b0;
		found = '0;
		for (int c = 0; c < LIMIT_CLASSES; c++) begin
			if (!hit && (req_q.request_size <= limit_q[c])) begin
				hit   = 1'b1;
				found = CLS_W'(c);
			end
		end
	end

	// Class selection and checks of the request.
	always_comb begin
		is_free   = (req_q.action == ACT_FREE);
		hcls_ok   = (32'(req_q.handle_class) < NUM_CLASSES);
		slot_ok   = (32'(req_q.handle_slot) < SLOTS_PER_CLASS);
		sel_cls   = is_free ? CLS_W'(req_q.handle_class) : found;
		head_sel  = head_q[sel_cls];
		used_sel  = used_q[sel_cls];
		total_sel = total_q[sel_cls];
		// Head values never exceed the slot count, so the wrap is a single compare.
		head_slot = (32'(head_sel) >= SLOTS_PER_CLASS) ? '0 : SLOT_W'(head_sel);
		free_slot = SLOT_W'(req_q.handle_slot);
		alloc_go  = !is_free && hit && (32'(used_sel) < SLOTS_PER_CLASS);
		free_go   = is_free && hcls_ok && slot_ok && (used_sel != '0);
	end

	// Result word of the request in lookup.
	always_comb begin
		res_d = '0;
		if (!is_free) begin
			if (!hit) begin
				res_d.status = ST_TOO_BIG;
			end else if (!alloc_go) begin
				res_d.status            = ST_EXHAUSTED;
				res_d.size_class        = 3'(sel_cls);
				res_d.class_in_use      = 7'(used_sel);
				res_d.class_alloc_total = total_sel;
			end else begin
				res_d.status            = ST_OK;
				res_d.size_class        = 3'(sel_cls);
				res_d.slot_index        = 6'(head_slot);
				res_d.class_in_use      = 7'(used_sel + LINK_W'(1));
				res_d.class_alloc_total = total_sel + 32'd1;
			end
		end else begin
			res_d.size_class = req_q.handle_class;
			if (!hcls_ok) begin
				res_d.status = ST_BAD_FREE;
			end else if (!free_go) begin
				res_d.status            = ST_BAD_FREE;
				res_d.class_in_use      = 7'(used_sel);
				res_d.class_alloc_total = total_sel;
			end else begin
				res_d.status            = ST_OK;
				res_d.slot_index        = req_q.handle_slot;
				res_d.class_in_use      = 7'(used_sel - LINK_W'(1));
				res_d.class_alloc_total = total_sel;
			end
		end
	end

	// Request register.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= in_word;
		end
	end

	// Limit registers; writes to indexes without a register are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < LIMIT_CLASSES; c++) begin
				limit_q[c] <= LIMIT_RESET[c];
			end
		end else begin
			for (int c = 0; c < LIMIT_CLASSES; c++) begin
				if (cfg_we && (cfg_index == CFG_IDX_W'(c))) begin
					limit_q[c] <= cfg_data;
				end
			end
		end
	end

	// Per-class head, in-use and allocation counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				head_q[c]  <= '0;
				used_q[c]  <= '0;
				total_q[c] <= '0;
			end
			pop_cls_q <= '0;
		end else begin
			if (cmd.lookup && alloc_go) begin
				used_q[sel_cls]  <= used_sel + LINK_W'(1);
				total_q[sel_cls] <= total_sel + 32'd1;
				pop_cls_q        <= sel_cls;
			end else if (cmd.lookup && free_go) begin
				used_q[sel_cls] <= used_sel - LINK_W'(1);
				head_q[sel_cls] <= LINK_W'(free_slot);
			end
			// The popped slot's link, read during lookup, becomes the new head in the pop state.
			if (cmd.pop) begin
				head_q[pop_cls_q] <= rd_q;
			end
		end
	end

	// Clearing sweep counters: class and slot of the entry being threaded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_cls_q  <= '0;
			init_slot_q <= '0;
		end else if (cmd.init_step) begin
			if (init_slot_q == SLOT_W'(SLOTS_PER_CLASS - 1)) begin
				init_slot_q <= '0;
				init_cls_q  <= init_cls_q + CLS_W'(1);
			end else begin
				init_slot_q <= init_slot_q + SLOT_W'(1);
			end
		end
	end

	// Link memory ports.
	always_comb begin
		mem_we    = cmd.init_step || (cmd.lookup && free_go);
		mem_waddr = cmd.init_step
			? ADDR_W'(ADDR_W'(init_cls_q) * ADDR_W'(SLOTS_PER_CLASS) + ADDR_W'(init_slot_q))
			: ADDR_W'(ADDR_W'(sel_cls) * ADDR_W'(SLOTS_PER_CLASS) + ADDR_W'(free_slot));
		mem_wdata = cmd.init_step ? (LINK_W'(init_slot_q) + LINK_W'(1)) : head_sel;
		mem_raddr = ADDR_W'(ADDR_W'(sel_cls) * ADDR_W'(SLOTS_PER_CLASS) + ADDR_W'(head_slot));
	end

	// Link memory with registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem[mem_waddr] <= mem_wdata;
		end
		if (cmd.lookup && alloc_go) begin
			rd_q <= link_mem[mem_raddr];
		end
	end

	// Output buffer: a result goes straight out when the output is free, else it is parked.
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			res_pend_q  <= 1'b0;
		end else begin
			if (cmd.lookup) begin
				if (out_free) begin
					out_valid_q <= 1'b1;
				end else begin
					res_pend_q <= 1'b1;
				end
			end else if (res_pend_q && out_free) begin
				out_valid_q <= 1'b1;
				res_pend_q  <= 1'b0;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			if (out_free) begin
				out_q <= res_d;
			end else begin
				res_q <= res_d;
			end
		end else if (res_pend_q && out_free) begin
			out_q <= res_q;
		end
	end

	// Status and outputs.
	assign status.init_last = cmd.init_step && (init_cls_q == CLS_W'(NUM_CLASSES - 1))
		&& (init_slot_q == SLOT_W'(SLOTS_PER_CLASS - 1));
	assign status.alloc_go  = alloc_go;
	assign status.res_pend  = res_pend_q;
	assign out_valid        = out_valid_q;
	assign out_word         = out_q;

endmodule

`default_nettype wire

FILE: sv/size_class_slot_allocator.sv
// Top level of the size-class slot allocator: controller, datapath and checks.
// Result: an accepted word is registered and looked up; its result is registered out or parked.
// Intake: for both allocate and free, no word is taken during lookup or while a result is
// parked; the pop's link read lands in the cycle after lookup, when the next word may be taken.
// Reset: asynchronous; afterwards a link-memory sweep over all NUM_CLASSES * SLOTS_PER_CLASS
// entries runs with in_stall high; configuration writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none

module size_class_slot_allocator (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_stall,
	input  scsa_pkg::in_word_t                 in_word,
	output logic                               out_valid,
	input  wire                                out_stall,
	output scsa_pkg::out_word_t                out_word,
	input  wire                                cfg_we,
	input  wire  [scsa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire  [scsa_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import scsa_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// Sequencer.
	scsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// Storage and arithmetic.
	scsa_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// No word is taken while the link memory is being threaded.
	a_no_accept_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.init_step |-> !cmd.accept)
		else $error("word accepted during link-memory sweep");

	// Every lookup works on a word accepted on the previous edge.
	a_lookup_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.lookup |-> $past(cmd.accept))
		else $error("lookup without an accepted word");

	// A pop only follows a lookup that granted a slot.
	a_pop_after_grant: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> $past(cmd.lookup && status.alloc_go))
		else $error("pop without a granted allocation");

	// A parked result never coexists with a lookup.
	a_no_lookup_when_parked: assert property (@(posedge clk) disable iff (!arst_n)
		status.res_pend |-> !cmd.lookup)
		else $error("lookup while a result is parked");

endmodule

`default_nettype wire
